@@ hw/rtl/mpd_pkg.sv @@
// types, codes and the symbol code table of the morse pulse decoder
`timescale 1ns / 1ps
`default_nettype none
package mpd_pkg;

   localparam int unsigned CODE_LEN_MAX = 5;

   localparam logic [31:0] DOT_MIN_RESET     = 32'd7500;
   localparam logic [31:0] DOT_MAX_RESET     = 32'd50000;
   localparam logic [3:0]  LETTER_GAP_RESET  = 4'd3;
   localparam logic [3:0]  WORD_GAP_RESET    = 4'd7;

   localparam logic [1:0] CSR_DOT_MIN    = 2'd0;
   localparam logic [1:0] CSR_DOT_MAX    = 2'd1;
   localparam logic [1:0] CSR_LETTER_GAP = 2'd2;
   localparam logic [1:0] CSR_WORD_GAP   = 2'd3;

   localparam logic OP_MARK = 1'b0;
   localparam logic OP_GAP  = 1'b1;

   localparam logic [1:0] KIND_ECHO  = 2'd0;
   localparam logic [1:0] KIND_CHAR  = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;
   localparam logic [1:0] KIND_SPACE = 2'd3;

   localparam logic [1:0] LAMP_NONE = 2'd0;
   localparam logic [1:0] LAMP_DOT  = 2'd1;
   localparam logic [1:0] LAMP_DASH = 2'd2;

   localparam logic [6:0] ASCII_DOT   = 7'h2E;
   localparam logic [6:0] ASCII_DASH  = 7'h2D;
   localparam logic [6:0] ASCII_SPACE = 7'h20;

   typedef struct packed {
      logic [1:0] kind;
      logic [6:0] char_code;
      logic [1:0] lamp_select;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic       hit;
      logic [6:0] char_code;
   } decode_type;

   // symbol i sits in bit i, dash is 1; key is {length, symbols}
   function automatic decode_type decode_code(input logic [2:0] len,
                                              input logic [4:0] bits);
      decode_type res;
      res.hit = 1'b1;
      case ({len, bits})
         {3'd2, 5'b00010}: res.char_code = 7'h41;
         {3'd4, 5'b00001}: res.char_code = 7'h42;
         {3'd4, 5'b00101}: res.char_code = 7'h43;
         {3'd3, 5'b00001}: res.char_code = 7'h44;
         {3'd1, 5'b00000}: res.char_code = 7'h45;
         {3'd4, 5'b00100}: res.char_code = 7'h46;
         {3'd3, 5'b00011}: res.char_code = 7'h47;
         {3'd4, 5'b00000}: res.char_code = 7'h48;
         {3'd2, 5'b00000}: res.char_code = 7'h49;
         {3'd4, 5'b01110}: res.char_code = 7'h4A;
         {3'd3, 5'b00101}: res.char_code = 7'h4B;
         {3'd4, 5'b00010}: res.char_code = 7'h4C;
         {3'd2, 5'b00011}: res.char_code = 7'h4D;
         {3'd2, 5'b00001}: res.char_code = 7'h4E;
         {3'd3, 5'b00111}: res.char_code = 7'h4F;
         {3'd4, 5'b00110}: res.char_code = 7'h50;
         {3'd4, 5'b01011}: res.char_code = 7'h51;
         {3'd3, 5'b00010}: res.char_code = 7'h52;
         {3'd3, 5'b00000}: res.char_code = 7'h53;
         {3'd1, 5'b00001}: res.char_code = 7'h54;
         {3'd3, 5'b00100}: res.char_code = 7'h55;
         {3'd4, 5'b01000}: res.char_code = 7'h56;
         {3'd3, 5'b00110}: res.char_code = 7'h57;
         {3'd4, 5'b01001}: res.char_code = 7'h58;
         {3'd4, 5'b01101}: res.char_code = 7'h59;
         {3'd4, 5'b00011}: res.char_code = 7'h5A;
         {3'd5, 5'b11111}: res.char_code = 7'h30;
         {3'd5, 5'b11110}: res.char_code = 7'h31;
         {3'd5, 5'b11100}: res.char_code = 7'h32;
         {3'd5, 5'b11000}: res.char_code = 7'h33;
         {3'd5, 5'b10000}: res.char_code = 7'h34;
         {3'd5, 5'b00000}: res.char_code = 7'h35;
         {3'd5, 5'b00001}: res.char_code = 7'h36;
         {3'd5, 5'b00011}: res.char_code = 7'h37;
         {3'd5, 5'b00111}: res.char_code = 7'h38;
         {3'd5, 5'b01111}: res.char_code = 7'h39;
         default: begin
            res.hit       = 1'b0;
            res.char_code = 7'd0;
         end
      endcase
      return res;
   endfunction

endpackage
`default_nettype wire

@@ hw/rtl/morse_pulse_decoder_unit.sv @@
// morse pulse decoder: key events in, echoes, characters and spaces out
//
//  channel  direction  tdata                      tuser      tlast
//  req_     in         duration_ticks[31:0]       op         -
//  rsp_     out        char_code[6:0], lamp[8:7]  kind[1:0]  last
//  csr_     in         write data, index 0..3     -          -
//
// an event is taken into an input register, then classified and decoded from
// that register against the dot timing and gap thresholds (one 4x32 multiply each),
// and its results are written into a two-entry result buffer once they fit.
// one event per cycle while results are taken; a gap that ends a word gives
// two results and waits until both buffer entries are free.
// reset is synchronous, clears the symbol buffer and the queues and loads the csrs with their reset values.
// a stalled result side fills the buffer, then the input register, then
// req_tready drops.
`timescale 1ns / 1ps
`default_nettype none
module morse_pulse_decoder_unit #(
   parameter int unsigned MAX_SYMBOLS = 5
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // duration_ticks[31:0]
   input  wire logic        req_tuser,   // op[0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // char_code[6:0], lamp_select[8:7], zero[15:9]
   output logic [1:0]       rsp_tuser,   // kind[1:0]
   output logic             rsp_tlast,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_addr,
   input  wire logic [31:0] csr_wdata
);

   localparam int unsigned CNT_W = $clog2(MAX_SYMBOLS + 1);

   logic [31:0] dot_min_ff, dot_max_ff;
   logic [3:0]  letter_gap_ff, word_gap_ff;

   logic        in_valid_ff, in_valid_in;
   logic        in_op_ff;
   logic [31:0] in_dur_ff;

   logic [MAX_SYMBOLS-1:0] sym_bits_ff, sym_bits_in;
   logic [CNT_W-1:0]       sym_count_ff, sym_count_in;

   mpd_pkg::rsp_type slot_ff [2];
   mpd_pkg::rsp_type slot_in [2];
   logic [1:0]       cnt_ff, cnt_in;

   logic             is_dot, is_dash;
   logic [35:0]      word_th, letter_th;
   logic             word_hit, letter_hit;
   mpd_pkg::decode_type dec;
   mpd_pkg::rsp_type res0, res1, dec_res;
   logic [1:0]       n_res, free, base;
   logic             take, pop;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dot_min_ff    <= mpd_pkg::DOT_MIN_RESET;
         dot_max_ff    <= mpd_pkg::DOT_MAX_RESET;
         letter_gap_ff <= mpd_pkg::LETTER_GAP_RESET;
         word_gap_ff   <= mpd_pkg::WORD_GAP_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            mpd_pkg::CSR_DOT_MIN:    dot_min_ff    <= csr_wdata;
            mpd_pkg::CSR_DOT_MAX:    dot_max_ff    <= csr_wdata;
            mpd_pkg::CSR_LETTER_GAP: letter_gap_ff <= csr_wdata[3:0];
            mpd_pkg::CSR_WORD_GAP:   word_gap_ff   <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // event classification, decoding and symbol buffer update
   always_comb begin
      is_dot     = (in_dur_ff > dot_min_ff) && (in_dur_ff < dot_max_ff);
      is_dash    = in_dur_ff > dot_max_ff;
      word_th    = {4'd0, dot_max_ff} * {32'd0, word_gap_ff};
      letter_th  = {4'd0, dot_max_ff} * {32'd0, letter_gap_ff};
      word_hit   = {4'd0, in_dur_ff} >= word_th;
      letter_hit = {4'd0, in_dur_ff} >= letter_th;
      dec        = mpd_pkg::decode_code(3'(sym_count_ff), sym_bits_ff[4:0]);

      dec_res.kind        = dec.hit ? mpd_pkg::KIND_CHAR : mpd_pkg::KIND_ERROR;
      dec_res.char_code   = dec.char_code;
      dec_res.lamp_select = mpd_pkg::LAMP_NONE;
      dec_res.last        = 1'b1;

      res1.kind        = mpd_pkg::KIND_SPACE;
      res1.char_code   = mpd_pkg::ASCII_SPACE;
      res1.lamp_select = mpd_pkg::LAMP_NONE;
      res1.last        = 1'b1;

      res0         = dec_res;
      n_res        = 2'd0;
      sym_bits_in  = sym_bits_ff;
      sym_count_in = sym_count_ff;

      if (in_op_ff == mpd_pkg::OP_MARK) begin
         res0.kind        = mpd_pkg::KIND_ECHO;
         res0.char_code   = is_dash ? mpd_pkg::ASCII_DASH : mpd_pkg::ASCII_DOT;
         res0.lamp_select = is_dash ? mpd_pkg::LAMP_DASH : mpd_pkg::LAMP_DOT;
         res0.last        = 1'b1;
         if (is_dot || is_dash) begin
            n_res = 2'd1;
            if (32'(sym_count_ff) < MAX_SYMBOLS) begin
               sym_bits_in  = sym_bits_ff |
                              (MAX_SYMBOLS'(is_dash) << sym_count_ff);
               sym_count_in = sym_count_ff + CNT_W'(1);
            end
         end
      end else if (word_hit) begin
         res0.last    = 1'b0;
         n_res        = 2'd2;
         sym_bits_in  = '0;
         sym_count_in = '0;
      end else if (letter_hit) begin
         n_res        = 2'd1;
         sym_bits_in  = '0;
         sym_count_in = '0;
      end
   end

   // handshake and result buffer
   always_comb begin
      pop         = rsp_tvalid && rsp_tready;
      free        = 2'd2 - cnt_ff + {1'b0, pop};
      take        = in_valid_ff && (n_res <= free);
      req_tready  = !in_valid_ff || take;
      in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !take);

      base = cnt_ff - {1'b0, pop};

      slot_in[0] = slot_ff[0];
      slot_in[1] = slot_ff[1];
      if (pop) begin
         slot_in[0] = slot_ff[1];
      end
      if (take && (n_res != 2'd0)) begin
         slot_in[base[0]] = res0;
      end
      if (take && (n_res == 2'd2)) begin
         slot_in[1] = res1;
      end
      cnt_in = base + (take ? n_res : 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         cnt_ff       <= 2'd0;
         sym_bits_ff  <= '0;
         sym_count_ff <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         cnt_ff      <= cnt_in;
         if (take) begin
            sym_bits_ff  <= sym_bits_in;
            sym_count_ff <= sym_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_op_ff  <= req_tuser;
         in_dur_ff <= req_tdata;
      end
      slot_ff[0] <= slot_in[0];
      slot_ff[1] <= slot_in[1];
   end

   assign rsp_tvalid = cnt_ff != 2'd0;
   assign rsp_tdata  = {7'd0, slot_ff[0].lamp_select, slot_ff[0].char_code};
   assign rsp_tuser  = slot_ff[0].kind;
   assign rsp_tlast  = slot_ff[0].last;

endmodule
`default_nettype wire
